// ----- hw/rtl/sttq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sttq_pkg
// Types, codes and sizes shared by the sorted timer queue core.
// ----------------------------------------------------------------------------
package sttq_pkg;

  localparam int SLOT_W    = 5;
  localparam int NUM_SLOTS = 1 << SLOT_W;
  localparam int DL_W      = 32;
  localparam int TASK_W    = 6;

  localparam logic [DL_W-1:0] NO_DEADLINE = '1;

  // opcodes
  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_FREE    = 3'd1;
  localparam logic [2:0] OP_INIT    = 3'd2;
  localparam logic [2:0] OP_SETTIME = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FAIL    = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;
  localparam logic [1:0] KIND_TASKSW  = 2'd3;

  // register index
  localparam logic CFG_TASK_IDX = 1'b0;

  typedef enum logic [1:0] {
    SL_FREE,
    SL_ALLOC,
    SL_RUN
  } slot_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_ALLOC,
    S_UHEAD,
    S_UWALK,
    S_UFIX,
    S_SET,
    S_ICMP,
    S_IW2,
    S_EARLY,
    S_TCMP,
    S_TEND,
    S_TTS
  } fsm_state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [4:0]  slot;
    logic [31:0] delay;
    logic [31:0] payload;
    logic [1:0]  queue_select;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  slot_out;
    logic [31:0] payload_out;
    logic [1:0]  queue_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic              dl_we;
    logic              link_we;
    logic              pq_we;
    logic [SLOT_W-1:0] addr;
    logic [DL_W-1:0]   dl;
    logic [SLOT_W-1:0] link;
    logic [31:0]       pay;
    logic [1:0]        q;
  } mem_wr_t;

  typedef struct packed {
    logic [DL_W-1:0]   dl;
    logic [SLOT_W-1:0] link;
    logic [31:0]       pay;
    logic [1:0]        q;
  } mem_rd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sorted_timeout_timer_queue_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timeout_timer_queue_core
// Timer slot pool with a deadline-sorted running list and a tick counter.
// ----------------------------------------------------------------------------
// An alloc scans the slots in order for a free one and fails when none is free;
//   settime unlinks a running timer by walking the list, then walks it again to
//   insert in deadline order; a due tick takes each expired timer in list order
//   and may end with a task switch. One item at a time, busy until done;
//   results show one cycle each, the receiver cannot stall.
// Reset (sync, rst_n low): tick 0, only the sentinel runs, task timer reg 32.
module sorted_timeout_timer_queue_core (
  input  wire                      clk,
  input  wire                      rst_n,
  // item channel
  input  wire                      start,
  output logic                     busy,
  input  sttq_pkg::in_item_t       in_item,
  // results
  output logic                     out_valid,
  output sttq_pkg::out_item_t      out_item,
  // configuration
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire  [2:0]               paddr,
  input  wire  [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import sttq_pkg::*;

  fsm_state_t          st_r, st_nxt;
  in_item_t            item_r;
  logic [DL_W-1:0]     tick_r, tick_nxt;
  logic [DL_W-1:0]     early_r, early_nxt;
  logic [SLOT_W-1:0]   head_r, head_nxt;
  logic [DL_W-1:0]     dl_r, dl_nxt;
  logic [SLOT_W-1:0]   cur_r, cur_nxt;
  logic [SLOT_W-1:0]   prev_r, prev_nxt;
  logic                first_r, first_nxt;
  logic                ts_r, ts_nxt;
  logic                pend_v_r, pend_v_nxt;
  out_item_t           pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;
  logic [TASK_W-1:0]   task_r;

  slot_state_t         slot_st_r [NUM_SLOTS];
  logic                sst_we;
  logic [SLOT_W-1:0]   sst_wa;
  slot_state_t         sst_wd;
  logic [SLOT_W-1:0]   sst_ra;
  slot_state_t         sst_rd;

  logic [SLOT_W-1:0]   rd_addr;
  mem_wr_t             mwr;
  mem_rd_t             mrd;

  // shared deadline comparator
  logic [DL_W-1:0]     cmp_a, cmp_b;
  logic                cmp_le;

  logic                accept;
  logic                cfg_wr;
  logic [SLOT_W-1:0]   item_slot;

  assign accept    = start && !busy;
  assign busy      = (st_r != S_IDLE);
  assign item_slot = item_r.slot;
  assign cmp_le    = (cmp_a <= cmp_b);
  assign sst_ra    = (st_r == S_ALLOC) ? cur_r : item_slot;
  assign sst_rd    = slot_st_r[sst_ra];

  sttq_slot_mem u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr      (mwr),
    .rd      (mrd)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_TASK_IDX) begin
      prdata = {{(32-TASK_W){1'b0}}, task_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_r <= TASK_W'(NUM_SLOTS);
    end else if (cfg_wr && (paddr[2] == CFG_TASK_IDX)) begin
      task_r <= pwdata[TASK_W-1:0];
    end
  end

  // slot state flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_st_r[i] <= (i == 0) ? SL_RUN : SL_FREE;
      end
    end else if (sst_we) begin
      slot_st_r[sst_wa] <= sst_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      tick_r      <= '0;
      early_r     <= NO_DEADLINE;
      head_r      <= '0;
      pend_v_r    <= 1'b0;
      ts_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      tick_r      <= tick_nxt;
      early_r     <= early_nxt;
      head_r      <= head_nxt;
      pend_v_r    <= pend_v_nxt;
      ts_r        <= ts_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    dl_r       <= dl_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    first_r    <= first_nxt;
    pend_r     <= pend_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // comparator operands follow the state only
  always_comb begin
    cmp_a = dl_r;
    cmp_b = mrd.dl;
    case (st_r)
      S_DISP: begin
        cmp_a = early_r;
        cmp_b = tick_r;
      end
      S_TCMP: begin
        cmp_a = mrd.dl;
        cmp_b = tick_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    tick_nxt      = tick_r;
    early_nxt     = early_r;
    head_nxt      = head_r;
    dl_nxt        = dl_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    first_nxt     = first_r;
    ts_nxt        = ts_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    sst_we        = 1'b0;
    sst_wa        = item_slot;
    sst_wd        = SL_RUN;
    rd_addr       = head_r;
    mwr           = '0;
    mwr.addr      = item_slot;

    case (st_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.opcode == OP_TICK) begin
            tick_nxt = tick_r + DL_W'(1);
          end
          st_nxt = S_DISP;
        end
      end

      S_DISP: begin
        // slot is 5 bits and the pool has 2^5 slots: no slot is out of range
        st_nxt = S_IDLE;
        case (item_r.opcode)
          OP_ALLOC: begin
            cur_nxt = '0;
            st_nxt  = S_ALLOC;
          end
          OP_FREE: begin
            if (sst_rd != SL_RUN) begin
              sst_we = 1'b1;
              sst_wd = SL_FREE;
            end
          end
          OP_INIT: begin
            mwr.pq_we = 1'b1;
            mwr.pay   = item_r.payload;
            mwr.q     = item_r.queue_select;
          end
          OP_SETTIME: begin
            if (item_slot != '0) begin
              dl_nxt = tick_r + item_r.delay;
              if (sst_rd != SL_RUN) begin
                st_nxt = S_SET;
              end else if (head_r == item_slot) begin
                rd_addr = item_slot;
                st_nxt  = S_UHEAD;
              end else begin
                rd_addr = head_r;
                cur_nxt = head_r;
                st_nxt  = S_UWALK;
              end
            end
          end
          OP_TICK: begin
            if (cmp_le) begin
              rd_addr    = head_r;
              cur_nxt    = head_r;
              ts_nxt     = 1'b0;
              pend_v_nxt = 1'b0;
              st_nxt     = S_TCMP;
            end
          end
          default: begin
            st_nxt = S_IDLE;
          end
        endcase
      end

      S_ALLOC: begin
        if (sst_rd == SL_FREE) begin
          sst_we        = 1'b1;
          sst_wa        = cur_r;
          sst_wd        = SL_ALLOC;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: KIND_ALLOC, slot_out: cur_r, payload_out: '0,
                            queue_out: '0, last: 1'b1};
          st_nxt        = S_IDLE;
        end else if (cur_r == SLOT_W'(NUM_SLOTS - 1)) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: KIND_FAIL, slot_out: '0, payload_out: '0,
                            queue_out: '0, last: 1'b1};
          st_nxt        = S_IDLE;
        end else begin
          cur_nxt = cur_r + SLOT_W'(1);
        end
      end

      S_UHEAD: begin
        head_nxt = mrd.link;
        st_nxt   = S_SET;
      end

      // cur_r is the node whose link is on the read port
      S_UWALK: begin
        if (mrd.link == item_slot) begin
          rd_addr = item_slot;
          st_nxt  = S_UFIX;
        end else if (cur_r == '0) begin
          st_nxt = S_SET;
        end else begin
          rd_addr = mrd.link;
          cur_nxt = mrd.link;
        end
      end

      S_UFIX: begin
        mwr.link_we = 1'b1;
        mwr.addr    = cur_r;
        mwr.link    = mrd.link;
        st_nxt      = S_SET;
      end

      S_SET: begin
        mwr.dl_we = 1'b1;
        mwr.dl    = dl_r;
        sst_we    = 1'b1;
        sst_wd    = SL_RUN;
        rd_addr   = head_r;
        cur_nxt   = head_r;
        first_nxt = 1'b1;
        st_nxt    = S_ICMP;
      end

      // insert before the first node whose deadline is not below ours;
      // the sentinel always stops the walk
      S_ICMP: begin
        if (cmp_le) begin
          if (first_r) begin
            mwr.link_we = 1'b1;
            mwr.link    = cur_r;
            head_nxt    = item_slot;
            early_nxt   = dl_r;
            st_nxt      = S_IDLE;
          end else begin
            mwr.link_we = 1'b1;
            mwr.addr    = prev_r;
            mwr.link    = item_slot;
            st_nxt      = S_IW2;
          end
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = mrd.link;
          rd_addr   = mrd.link;
          first_nxt = 1'b0;
        end
      end

      S_IW2: begin
        mwr.link_we = 1'b1;
        mwr.link    = cur_r;
        rd_addr     = head_r;
        st_nxt      = S_EARLY;
      end

      S_EARLY: begin
        early_nxt = mrd.dl;
        st_nxt    = S_IDLE;
      end

      // at most NUM_SLOTS-1 timers can be due; the walk stops at the sentinel or the first timer not yet due
      S_TCMP: begin
        if ((cur_r != '0) && cmp_le) begin
          sst_we = 1'b1;
          sst_wa = cur_r;
          sst_wd = SL_ALLOC;
          if ({1'b0, cur_r} == task_r) begin
            ts_nxt = 1'b1;
          end else begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = pend_r;
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = '{kind: KIND_EXPIRED, slot_out: cur_r, payload_out: mrd.pay,
                           queue_out: mrd.q, last: 1'b0};
          end
          rd_addr = mrd.link;
          cur_nxt = mrd.link;
        end else begin
          head_nxt  = cur_r;
          early_nxt = mrd.dl;
          st_nxt    = S_TEND;
        end
      end

      S_TEND: begin
        st_nxt = S_IDLE;
        if (pend_v_r) begin
          out_valid_nxt     = 1'b1;
          out_item_nxt      = pend_r;
          out_item_nxt.last = !ts_r;
          pend_v_nxt        = 1'b0;
          if (ts_r) begin
            st_nxt = S_TTS;
          end
        end else if (ts_r) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: KIND_TASKSW, slot_out: task_r[SLOT_W-1:0],
                            payload_out: '0, queue_out: '0, last: 1'b1};
        end
      end

      S_TTS: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{kind: KIND_TASKSW, slot_out: task_r[SLOT_W-1:0],
                          payload_out: '0, queue_out: '0, last: 1'b1};
        st_nxt        = S_IDLE;
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // the sentinel never leaves the running list
  a_sentinel_run: assert property (@(posedge clk) disable iff (!rst_n)
    slot_st_r[0] == SL_RUN)
    else $error("sentinel slot left running state");

  // an empty list means no pending deadline
  a_empty_early: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && head_r == '0) |-> (early_r == NO_DEADLINE))
    else $error("earliest deadline out of step with empty list");

  // the last result of an item is never followed at once by another
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |=> !out_valid)
    else $error("result right after a final result");

  // an accepted item makes the core busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a pending expiry is always flushed before the core goes idle
  a_pend_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !pend_v_r)
    else $error("expiry result left pending");

endmodule
`default_nettype wire

// ----- hw/rtl/sttq_slot_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sttq_slot_mem
// Per-slot deadline, link, payload and queue storage. One write and one
// registered read per cycle. Slot 0 is the sentinel: it reads back with
// deadline all ones and link 0, whatever the arrays hold.
// ----------------------------------------------------------------------------
module sttq_slot_mem (
  input  wire                          clk,
  input  wire  [sttq_pkg::SLOT_W-1:0]  rd_addr,
  input  sttq_pkg::mem_wr_t            wr,
  output sttq_pkg::mem_rd_t            rd
);
  import sttq_pkg::*;

  logic [DL_W-1:0]   dl_mem   [NUM_SLOTS];
  logic [SLOT_W-1:0] link_mem [NUM_SLOTS];
  logic [31:0]       pay_mem  [NUM_SLOTS];
  logic [1:0]        q_mem    [NUM_SLOTS];

  logic [DL_W-1:0]   dl_r;
  logic [SLOT_W-1:0] link_r;
  logic [31:0]       pay_r;
  logic [1:0]        q_r;
  logic              zero_r;

  always_ff @(posedge clk) begin
    if (wr.dl_we) begin
      dl_mem[wr.addr] <= wr.dl;
    end
    if (wr.link_we) begin
      link_mem[wr.addr] <= wr.link;
    end
    if (wr.pq_we) begin
      pay_mem[wr.addr] <= wr.pay;
      q_mem[wr.addr]   <= wr.q;
    end
  end

  always_ff @(posedge clk) begin
    dl_r   <= dl_mem[rd_addr];
    link_r <= link_mem[rd_addr];
    pay_r  <= pay_mem[rd_addr];
    q_r    <= q_mem[rd_addr];
    zero_r <= (rd_addr == '0);
  end

  assign rd.dl   = zero_r ? NO_DEADLINE : dl_r;
  assign rd.link = zero_r ? '0 : link_r;
  assign rd.pay  = pay_r;
  assign rd.q    = q_r;

endmodule
`default_nettype wire
